>>> rtl/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the cell balance selector.
// ----------------------------------------------------------------------------
package cbs_pkg;

    localparam int CELLS_PER_GROUP_DEF = 12;
    localparam int GROUPS_DEF          = 2;

    localparam int VOLT_W  = 16;
    localparam int TEMP_W  = 12;
    localparam int MASK_W  = 12;
    localparam int COUNT_W = 4;
    localparam int MARGIN_W = 10;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic [2:0] REG_CELLS_IN_USE = 3'd0;
    localparam logic [2:0] REG_MAX_SELECTED = 3'd1;
    localparam logic [2:0] REG_MARGIN       = 3'd2;
    localparam logic [2:0] REG_TRIP_TEMP    = 3'd3;
    localparam logic [2:0] REG_RELEASE_TEMP = 3'd4;

    localparam logic [3:0]          RST_CELLS_IN_USE = 4'd12;
    localparam logic [3:0]          RST_MAX_SELECTED = 4'd4;
    localparam logic [MARGIN_W-1:0] RST_MARGIN       = 10'd10;
    localparam logic [TEMP_W-1:0]   RST_TRIP_TEMP    = 12'd600;
    localparam logic [TEMP_W-1:0]   RST_RELEASE_TEMP = 12'd500;

    typedef struct packed {
        logic                     opcode;
        logic [VOLT_W-1:0]        cell_voltage;
        logic                     group_index;
        logic signed [TEMP_W-1:0] balance_temp;
        logic [VOLT_W-1:0]        group_average;
        logic [VOLT_W-1:0]        pack_average;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]  discharge_mask;
        logic [COUNT_W-1:0] selected_count;
        logic               thermal_inhibit;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/cbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/cell_balance_selector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_balance_selector_core
// Chooses which cells of a monitor group to discharge.
// ----------------------------------------------------------------------------
// A load command keeps busy low. A run command with the
// group tripped, or with no cells or no selections allowed, keeps busy high for
// one cycle and shows its result with done in the cycle right after the
// transfer. Otherwise the run ranks the cells by repeated sweeps through the
// cell memory, one read per cycle and one sweep per ranked cell, so busy stays
// high until all n cells in use are ranked, ending early once the selection
// limit is reached. The result is shown with done for one cycle and cannot be
// held off by the receiver.
module cell_balance_selector_core #(
    parameter int CELLS_PER_GROUP = cbs_pkg::CELLS_PER_GROUP_DEF,
    parameter int GROUPS          = cbs_pkg::GROUPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cbs_pkg::cmd_t               cmd,
    output logic                        done,
    output cbs_pkg::result_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [cbs_pkg::DATA_W-1:0]  pwdata,
    output logic [cbs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int CI_W  = CELLS_PER_GROUP > 1 ? $clog2(CELLS_PER_GROUP) : 1;
    localparam int CNT_W = $clog2(CELLS_PER_GROUP + 1);
    localparam int G_W   = GROUPS > 1 ? $clog2(GROUPS) : 1;
    localparam int THR_W = cbs_pkg::VOLT_W + 1;

    cbs_pkg::state_t state_reg, state_next;

    logic [3:0]                          cells_in_use_reg;
    logic [3:0]                          max_selected_reg;
    logic [cbs_pkg::MARGIN_W-1:0]        margin_reg;
    logic signed [cbs_pkg::TEMP_W-1:0]   trip_temp_reg;
    logic signed [cbs_pkg::TEMP_W-1:0]   release_temp_reg;

    logic [CI_W-1:0]            load_pos_reg, load_pos_next;
    logic [GROUPS-1:0]          tripped_reg, tripped_next;
    logic [CELLS_PER_GROUP-1:0] ranked_reg, ranked_next;
    logic [CELLS_PER_GROUP-1:0] alive_reg, alive_next;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic [CNT_W-1:0]           rank_reg, rank_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       found_reg, found_next;

    logic [CI_W-1:0]                 tag_reg, tag_next;
    logic [CI_W-1:0]                 best_idx_reg, best_idx_next;
    logic [cbs_pkg::VOLT_W-1:0]      best_v_reg, best_v_next;
    logic [THR_W-1:0]                gthr_reg, gthr_next;
    logic [THR_W-1:0]                pthr_reg, pthr_next;
    logic [cbs_pkg::MASK_W-1:0]      mask_reg, mask_next;
    logic [cbs_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                            inhibit_reg, inhibit_next;

    logic                       accept;
    logic                       cfg_write;
    logic [4:0]                 n_wide;
    logic [CNT_W-1:0]           n;
    logic [G_W-1:0]             grp;
    logic                       trip_new;
    logic                       ram_we;
    logic                       ram_re;
    logic [cbs_pkg::VOLT_W-1:0] ram_rdata;
    logic                       take;
    logic                       last;
    logic [CI_W-1:0]            best_fin;
    logic [cbs_pkg::VOLT_W-1:0] best_v_fin;
    logic [CELLS_PER_GROUP-1:0] best_hot;
    logic [CELLS_PER_GROUP-1:0] neighbors;
    logic                       alive_ok;
    logic                       chosen;
    logic                       run_end;
    logic [CNT_W:0]             load_inc;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign n_wide = ({1'b0, cells_in_use_reg} > 5'(CELLS_PER_GROUP))
                    ? 5'(CELLS_PER_GROUP) : {1'b0, cells_in_use_reg};
    assign n      = CNT_W'(n_wide);

    assign grp = (GROUPS > 1) ? G_W'(cmd.group_index) : '0;

    always_comb
    begin
        trip_new = tripped_reg[grp];
        if (cmd.balance_temp > trip_temp_reg)
        begin
            trip_new = 1'b1;
        end
        else if (cmd.balance_temp < release_temp_reg)
        begin
            trip_new = 1'b0;
        end
    end

    assign ram_we = accept && (cmd.opcode == cbs_pkg::OP_LOAD);
    assign ram_re = (state_reg == cbs_pkg::ST_SWEEP) && (issue_reg < n);

    cbs_ram #(
        .WIDTH (cbs_pkg::VOLT_W),
        .DEPTH (CELLS_PER_GROUP)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_pos_reg),
        .wdata (cmd.cell_voltage),
        .re    (ram_re),
        .raddr (issue_reg[CI_W-1:0]),
        .rdata (ram_rdata)
    );

    assign take       = !ranked_reg[tag_reg] && (!found_reg || (ram_rdata > best_v_reg));
    assign last       = rd_vld_reg && (CNT_W'(tag_reg) == (n - CNT_W'(1)));
    assign best_fin   = take ? tag_reg : best_idx_reg;
    assign best_v_fin = take ? ram_rdata : best_v_reg;
    assign best_hot   = CELLS_PER_GROUP'(1) << best_fin;
    assign neighbors  = (alive_reg << 1) | (alive_reg >> 1);
    assign alive_ok   = !neighbors[best_fin];
    assign chosen     = alive_ok && ((THR_W'(best_v_fin) > gthr_reg)
                                     || (THR_W'(best_v_fin) > pthr_reg));
    assign run_end    = ((rank_reg + CNT_W'(1)) == n)
                        || (chosen && ((count_reg + 4'd1) == max_selected_reg));
    assign load_inc   = (CNT_W + 1)'(load_pos_reg) + (CNT_W + 1)'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbs_pkg::ST_IDLE:
            begin
                if (accept && (cmd.opcode == cbs_pkg::OP_RUN))
                begin
                    if (trip_new || (n == '0) || (max_selected_reg == 4'd0))
                    begin
                        state_next = cbs_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = cbs_pkg::ST_SWEEP;
                    end
                end
            end
            cbs_pkg::ST_SWEEP:
            begin
                if (last && run_end)
                begin
                    state_next = cbs_pkg::ST_FINISH;
                end
            end
            cbs_pkg::ST_FINISH:
            begin
                state_next = cbs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy                   = (state_reg != cbs_pkg::ST_IDLE);
        done                   = (state_reg == cbs_pkg::ST_FINISH);
        result.discharge_mask  = mask_reg;
        result.selected_count  = count_reg;
        result.thermal_inhibit = inhibit_reg;
    end

    always_comb
    begin
        load_pos_next = load_pos_reg;
        tripped_next  = tripped_reg;
        ranked_next   = ranked_reg;
        alive_next    = alive_reg;
        issue_next    = issue_reg;
        rank_next     = rank_reg;
        rd_vld_next   = ram_re;
        found_next    = found_reg;
        tag_next      = issue_reg[CI_W-1:0];
        best_idx_next = best_idx_reg;
        best_v_next   = best_v_reg;
        gthr_next     = gthr_reg;
        pthr_next     = pthr_reg;
        mask_next     = mask_reg;
        count_next    = count_reg;
        inhibit_next  = inhibit_reg;

        if (ram_re)
        begin
            issue_next = issue_reg + CNT_W'(1);
        end

        if (accept && (cmd.opcode == cbs_pkg::OP_LOAD))
        begin
            if (load_inc >= (CNT_W + 1)'(n))
            begin
                load_pos_next = '0;
            end
            else
            begin
                load_pos_next = CI_W'(load_inc);
            end
        end
        else if (accept)
        begin
            load_pos_next     = '0;
            tripped_next[grp] = trip_new;
            ranked_next       = '0;
            alive_next        = '0;
            issue_next        = '0;
            rank_next         = '0;
            found_next        = 1'b0;
            gthr_next         = THR_W'(cmd.group_average) + THR_W'(margin_reg);
            pthr_next         = THR_W'(cmd.pack_average) + THR_W'(margin_reg);
            mask_next         = '0;
            count_next        = '0;
            inhibit_next      = trip_new;
        end

        if (rd_vld_reg)
        begin
            if (last)
            begin
                ranked_next = ranked_reg | best_hot;
                if (alive_ok)
                begin
                    alive_next = alive_reg | best_hot;
                end
                if (chosen)
                begin
                    mask_next  = mask_reg | (cbs_pkg::MASK_W'(1) << best_fin);
                    count_next = count_reg + 4'd1;
                end
                rank_next  = rank_reg + CNT_W'(1);
                found_next = 1'b0;
                issue_next = '0;
            end
            else
            begin
                best_idx_next = best_fin;
                best_v_next   = best_v_fin;
                found_next    = found_reg || take;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cbs_pkg::ST_IDLE;
            load_pos_reg <= '0;
            tripped_reg <= '0;
            ranked_reg  <= '0;
            alive_reg   <= '0;
            issue_reg   <= '0;
            rank_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            load_pos_reg <= load_pos_next;
            tripped_reg <= tripped_next;
            ranked_reg  <= ranked_next;
            alive_reg   <= alive_next;
            issue_reg   <= issue_next;
            rank_reg    <= rank_next;
            rd_vld_reg  <= rd_vld_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        best_idx_reg <= best_idx_next;
        best_v_reg   <= best_v_next;
        gthr_reg     <= gthr_next;
        pthr_reg     <= pthr_next;
        mask_reg     <= mask_next;
        count_reg    <= count_next;
        inhibit_reg  <= inhibit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_in_use_reg <= cbs_pkg::RST_CELLS_IN_USE;
            max_selected_reg <= cbs_pkg::RST_MAX_SELECTED;
            margin_reg       <= cbs_pkg::RST_MARGIN;
            trip_temp_reg    <= cbs_pkg::RST_TRIP_TEMP;
            release_temp_reg <= cbs_pkg::RST_RELEASE_TEMP;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                cbs_pkg::REG_CELLS_IN_USE: cells_in_use_reg <= pwdata[3:0];
                cbs_pkg::REG_MAX_SELECTED: max_selected_reg <= pwdata[3:0];
                cbs_pkg::REG_MARGIN:       margin_reg <= pwdata[cbs_pkg::MARGIN_W-1:0];
                cbs_pkg::REG_TRIP_TEMP:    trip_temp_reg <= pwdata[cbs_pkg::TEMP_W-1:0];
                cbs_pkg::REG_RELEASE_TEMP: release_temp_reg <= pwdata[cbs_pkg::TEMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            cbs_pkg::REG_CELLS_IN_USE: prdata = 32'(cells_in_use_reg);
            cbs_pkg::REG_MAX_SELECTED: prdata = 32'(max_selected_reg);
            cbs_pkg::REG_MARGIN:       prdata = 32'(margin_reg);
            cbs_pkg::REG_TRIP_TEMP:    prdata = 32'(trip_temp_reg);
            cbs_pkg::REG_RELEASE_TEMP: prdata = 32'(release_temp_reg);
            default:                   prdata = '0;
        endcase
    end

endmodule

>>> rtl/cbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_checker
// Port-level checks of the cell balance selector, bound to the top level.
// ----------------------------------------------------------------------------
module cbs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input cbs_pkg::cmd_t    cmd,
    input logic             done,
    input cbs_pkg::result_t result
);

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result transfer while the block is idle.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    a_inhibit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.thermal_inhibit) |->
            (result.discharge_mask == '0) && (result.selected_count == '0))
        else $error("Tripped group reported selected cells.");

    a_no_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.discharge_mask & (result.discharge_mask >> 1)) == '0))
        else $error("Two neighboring cells were selected.");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == cbs_pkg::OP_LOAD)) |=> !busy)
        else $error("Load transfer made the block busy.");

endmodule

bind cell_balance_selector_core cbs_checker u_cbs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
